@@ src/apsq_pkg.sv @@
package apsq_pkg;

  localparam int unsigned WORDS_PER_SECTOR = 256;

  localparam logic [7:0] SEL_MASTER = 8'he0;
  localparam logic [7:0] SEL_SLAVE  = 8'hf0;
  localparam logic [7:0] SRST_BIT   = 8'h04;
  localparam logic [7:0] CMD_READ   = 8'h20;
  localparam logic [7:0] CMD_WRITE  = 8'h30;

  localparam int unsigned ST_BSY = 7;
  localparam int unsigned ST_DRQ = 3;
  localparam int unsigned ST_ERR = 0;

  localparam logic [15:0] OFS_DATA    = 16'd0;
  localparam logic [15:0] OFS_COUNT   = 16'd2;
  localparam logic [15:0] OFS_LBA_LO  = 16'd3;
  localparam logic [15:0] OFS_LBA_MID = 16'd4;
  localparam logic [15:0] OFS_LBA_HI  = 16'd5;
  localparam logic [15:0] OFS_DRIVE   = 16'd6;
  localparam logic [15:0] OFS_CMD     = 16'd7;
  localparam logic [15:0] OFS_ALTSTAT = 16'd2;

  typedef enum logic [1:0] {
    OP_READ_REQ  = 2'd0,
    OP_WRITE_REQ = 2'd1,
    OP_REPLY     = 2'd2,
    OP_HOST_WORD = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    KIND_SETTLE = 3'd0,
    KIND_BREAD  = 3'd1,
    KIND_BWRITE = 3'd2,
    KIND_WREAD  = 3'd3,
    KIND_WWRITE = 3'd4,
    KIND_HOST   = 3'd5,
    KIND_DONE   = 3'd6
  } kind_t;

  typedef enum logic [1:0] {
    CFG_CMD_BASE    = 2'd0,
    CFG_CTRL_BASE   = 2'd1,
    CFG_DRIVE_SLAVE = 2'd2
  } cfg_idx_t;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_POLL  = 4'b0010,
    PH_RDATA = 4'b0100,
    PH_WDATA = 4'b1000
  } phase_t;

  typedef enum logic [3:0] {
    J_REQ         = 4'd0,
    J_SRST        = 4'd1,
    J_DONE        = 4'd2,
    J_POLL        = 4'd3,
    J_WREAD       = 4'd4,
    J_HOST_MORE   = 4'd5,
    J_HOST_END    = 4'd6,
    J_WWRITE_MORE = 4'd7,
    J_WWRITE_END  = 4'd8
  } job_kind_t;

  typedef struct packed {
    job_kind_t   jkind;
    logic        wr;
    logic [27:0] lba;
    logic [7:0]  cnt;
    logic [15:0] data;
  } job_t;

  typedef struct packed {
    logic [15:0] cmd_base;
    logic [15:0] ctrl_base;
    logic        drive_slave;
  } cfg_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] bus_addr;
    logic [15:0] value;
    logic        failed;
    logic        last;
  } result_t;

endpackage

@@ src/apsq_front.sv @@
module apsq_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  logic [1:0]         op,
  input  logic [27:0]        block_addr,
  input  logic [7:0]         sector_count,
  input  logic [15:0]        data_in,
  output logic               job_push,
  output apsq_pkg::job_t     job
);

  apsq_pkg::phase_t phase_r, phase_nxt;
  logic             is_write_r, is_write_nxt;
  logic [15:0]      words_left_r, words_left_nxt;
  logic [15:0]      words_dec;
  logic [7:0]       st;

  assign words_dec = words_left_r - 16'd1;
  assign st        = data_in[7:0];

  always_comb begin
    phase_nxt      = phase_r;
    is_write_nxt   = is_write_r;
    words_left_nxt = words_left_r;
    job_push       = 1'b0;
    job.jkind      = apsq_pkg::J_DONE;
    job.wr         = op[0];
    job.lba        = block_addr;
    job.cnt        = sector_count;
    job.data       = data_in;
    if (accept) begin
      unique case (apsq_pkg::op_t'(op))
        apsq_pkg::OP_READ_REQ, apsq_pkg::OP_WRITE_REQ: begin
          if (phase_r == apsq_pkg::PH_IDLE) begin
            job_push       = 1'b1;
            job.jkind      = apsq_pkg::J_REQ;
            phase_nxt      = apsq_pkg::PH_POLL;
            is_write_nxt   = op[0];
            words_left_nxt = {sector_count, 8'h00};
          end
        end
        apsq_pkg::OP_REPLY: begin
          if (phase_r == apsq_pkg::PH_POLL) begin
            priority if (st[apsq_pkg::ST_ERR]) begin
              job_push       = 1'b1;
              job.jkind      = apsq_pkg::J_SRST;
              phase_nxt      = apsq_pkg::PH_IDLE;
              words_left_nxt = '0;
            end else if (!st[apsq_pkg::ST_BSY] && st[apsq_pkg::ST_DRQ]) begin
              priority if (words_left_r == '0) begin
                job_push  = 1'b1;
                job.jkind = apsq_pkg::J_DONE;
                phase_nxt = apsq_pkg::PH_IDLE;
              end else if (is_write_r) begin
                phase_nxt = apsq_pkg::PH_WDATA;
              end else begin
                job_push  = 1'b1;
                job.jkind = apsq_pkg::J_WREAD;
                phase_nxt = apsq_pkg::PH_RDATA;
              end
            end else begin
              job_push  = 1'b1;
              job.jkind = apsq_pkg::J_POLL;
            end
          end else if (phase_r == apsq_pkg::PH_RDATA) begin
            job_push       = 1'b1;
            words_left_nxt = words_dec;
            if (words_dec == '0) begin
              job.jkind = apsq_pkg::J_HOST_END;
              phase_nxt = apsq_pkg::PH_IDLE;
            end else begin
              job.jkind = apsq_pkg::J_HOST_MORE;
            end
          end
        end
        apsq_pkg::OP_HOST_WORD: begin
          if (phase_r == apsq_pkg::PH_WDATA) begin
            job_push       = 1'b1;
            words_left_nxt = words_dec;
            if (words_dec == '0) begin
              job.jkind = apsq_pkg::J_WWRITE_END;
              phase_nxt = apsq_pkg::PH_IDLE;
            end else begin
              job.jkind = apsq_pkg::J_WWRITE_MORE;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= apsq_pkg::PH_IDLE;
      is_write_r   <= 1'b0;
      words_left_r <= '0;
    end else begin
      phase_r      <= phase_nxt;
      is_write_r   <= is_write_nxt;
      words_left_r <= words_left_nxt;
    end
  end

endmodule

@@ src/apsq_queue.sv @@
module apsq_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  apsq_pkg::job_t push_job,
  input  logic           pop,
  output logic           full,
  output logic           valid,
  output apsq_pkg::job_t head
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  apsq_pkg::job_t   slot_r [DEPTH];
  logic [PTR_W-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_FULL);
  assign valid   = (cnt_r != '0);
  assign head    = slot_r[rp_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wp_nxt = (wp_r == PTR_LAST) ? '0 : wp_r + PTR_W'(1);
    end
    if (do_pop) begin
      rp_nxt = (rp_r == PTR_LAST) ? '0 : rp_r + PTR_W'(1);
    end
    unique case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + CNT_W'(1);
      2'b01:   cnt_nxt = cnt_r - CNT_W'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wp_r] <= push_job;
    end
  end

endmodule

@@ src/apsq_back.sv @@
module apsq_back #(
  parameter int unsigned SETTLE_READS = 5
) (
  input  logic              clk,
  input  logic              rst_n,
  input  apsq_pkg::cfg_t    cfg,
  input  logic              job_valid,
  input  apsq_pkg::job_t    job,
  output logic              job_pop,
  input  logic              res_pop,
  output logic              res_valid,
  output apsq_pkg::result_t res
);

  localparam int unsigned S      = SETTLE_READS;
  localparam int unsigned STEP_W = $clog2(2 * S + 7);
  localparam logic [STEP_W-1:0] R_SET1_END = STEP_W'(S);
  localparam logic [STEP_W-1:0] R_CNT      = STEP_W'(S + 1);
  localparam logic [STEP_W-1:0] R_LBA_LO   = STEP_W'(S + 2);
  localparam logic [STEP_W-1:0] R_LBA_MID  = STEP_W'(S + 3);
  localparam logic [STEP_W-1:0] R_LBA_HI   = STEP_W'(S + 4);
  localparam logic [STEP_W-1:0] R_CMD      = STEP_W'(S + 5);
  localparam logic [STEP_W-1:0] R_SET2_END = STEP_W'(2 * S + 5);
  localparam logic [STEP_W-1:0] R_LAST     = STEP_W'(2 * S + 6);
  localparam logic [STEP_W-1:0] X_CLR      = STEP_W'(S + 1);
  localparam logic [STEP_W-1:0] X_SET2_END = STEP_W'(2 * S + 1);
  localparam logic [STEP_W-1:0] X_LAST     = STEP_W'(2 * S + 2);
  localparam logic [STEP_W-1:0] STEP_ONE   = STEP_W'(1);

  logic [STEP_W-1:0] step_r, step_nxt;
  logic [STEP_W-1:0] last_step;
  logic              res_valid_r, res_valid_nxt;
  apsq_pkg::result_t res_r, cur;
  logic              go;
  logic [15:0]       settle_addr, srst_addr;
  logic [7:0]        sel;

  assign settle_addr = cfg.ctrl_base + apsq_pkg::OFS_ALTSTAT;
  assign srst_addr   = cfg.ctrl_base + apsq_pkg::OFS_ALTSTAT;
  assign sel = (cfg.drive_slave ? apsq_pkg::SEL_SLAVE : apsq_pkg::SEL_MASTER)
               | {4'h0, job.lba[27:24]};

  always_comb begin
    cur.kind     = apsq_pkg::KIND_SETTLE;
    cur.bus_addr = settle_addr;
    cur.value    = '0;
    cur.failed   = 1'b0;
    last_step    = '0;
    unique case (job.jkind)
      apsq_pkg::J_REQ: begin
        last_step = R_LAST;
        priority if (step_r == '0) begin
          cur.kind     = apsq_pkg::KIND_BWRITE;
          cur.bus_addr = cfg.cmd_base + apsq_pkg::OFS_DRIVE;
          cur.value    = {8'h00, sel};
        end else if (step_r <= R_SET1_END) begin
          cur.kind = apsq_pkg::KIND_SETTLE;
        end else if (step_r == R_CNT) begin
          cur.kind     = apsq_pkg::KIND_BWRITE;
          cur.bus_addr = cfg.cmd_base + apsq_pkg::OFS_COUNT;
          cur.value    = {8'h00, job.cnt};
        end else if (step_r == R_LBA_LO) begin
          cur.kind     = apsq_pkg::KIND_BWRITE;
          cur.bus_addr = cfg.cmd_base + apsq_pkg::OFS_LBA_LO;
          cur.value    = {8'h00, job.lba[7:0]};
        end else if (step_r == R_LBA_MID) begin
          cur.kind     = apsq_pkg::KIND_BWRITE;
          cur.bus_addr = cfg.cmd_base + apsq_pkg::OFS_LBA_MID;
          cur.value    = {8'h00, job.lba[15:8]};
        end else if (step_r == R_LBA_HI) begin
          cur.kind     = apsq_pkg::KIND_BWRITE;
          cur.bus_addr = cfg.cmd_base + apsq_pkg::OFS_LBA_HI;
          cur.value    = {8'h00, job.lba[23:16]};
        end else if (step_r == R_CMD) begin
          cur.kind     = apsq_pkg::KIND_BWRITE;
          cur.bus_addr = cfg.cmd_base + apsq_pkg::OFS_CMD;
          cur.value    = {8'h00, job.wr ? apsq_pkg::CMD_WRITE : apsq_pkg::CMD_READ};
        end else if (step_r <= R_SET2_END) begin
          cur.kind = apsq_pkg::KIND_SETTLE;
        end else begin
          cur.kind     = apsq_pkg::KIND_BREAD;
          cur.bus_addr = cfg.cmd_base + apsq_pkg::OFS_CMD;
        end
      end
      apsq_pkg::J_SRST: begin
        last_step = X_LAST;
        priority if (step_r == '0) begin
          cur.kind     = apsq_pkg::KIND_BWRITE;
          cur.bus_addr = srst_addr;
          cur.value    = {8'h00, apsq_pkg::SRST_BIT};
        end else if (step_r <= R_SET1_END) begin
          cur.kind = apsq_pkg::KIND_SETTLE;
        end else if (step_r == X_CLR) begin
          cur.kind     = apsq_pkg::KIND_BWRITE;
          cur.bus_addr = srst_addr;
        end else if (step_r <= X_SET2_END) begin
          cur.kind = apsq_pkg::KIND_SETTLE;
        end else begin
          cur.kind     = apsq_pkg::KIND_DONE;
          cur.bus_addr = '0;
          cur.failed   = 1'b1;
        end
      end
      apsq_pkg::J_DONE: begin
        cur.kind     = apsq_pkg::KIND_DONE;
        cur.bus_addr = '0;
      end
      apsq_pkg::J_POLL: begin
        cur.kind     = apsq_pkg::KIND_BREAD;
        cur.bus_addr = cfg.cmd_base + apsq_pkg::OFS_CMD;
      end
      apsq_pkg::J_WREAD: begin
        cur.kind     = apsq_pkg::KIND_WREAD;
        cur.bus_addr = cfg.cmd_base + apsq_pkg::OFS_DATA;
      end
      apsq_pkg::J_HOST_MORE, apsq_pkg::J_HOST_END: begin
        last_step = STEP_ONE;
        if (step_r == '0) begin
          cur.kind     = apsq_pkg::KIND_HOST;
          cur.bus_addr = '0;
          cur.value    = job.data;
        end else if (job.jkind == apsq_pkg::J_HOST_END) begin
          cur.kind     = apsq_pkg::KIND_DONE;
          cur.bus_addr = '0;
        end else begin
          cur.kind     = apsq_pkg::KIND_WREAD;
          cur.bus_addr = cfg.cmd_base + apsq_pkg::OFS_DATA;
        end
      end
      apsq_pkg::J_WWRITE_MORE, apsq_pkg::J_WWRITE_END: begin
        last_step = (job.jkind == apsq_pkg::J_WWRITE_END) ? STEP_ONE : '0;
        if (step_r == '0) begin
          cur.kind     = apsq_pkg::KIND_WWRITE;
          cur.bus_addr = cfg.cmd_base + apsq_pkg::OFS_DATA;
          cur.value    = job.data;
        end else begin
          cur.kind     = apsq_pkg::KIND_DONE;
          cur.bus_addr = '0;
        end
      end
      default: begin
      end
    endcase
    cur.last = (step_r == last_step);
  end

  assign go      = job_valid && (!res_valid_r || res_pop);
  assign job_pop = go && cur.last;

  always_comb begin
    step_nxt      = step_r;
    res_valid_nxt = res_valid_r;
    if (go) begin
      res_valid_nxt = 1'b1;
      step_nxt      = cur.last ? '0 : step_r + STEP_ONE;
    end else if (res_pop) begin
      res_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= '0;
      res_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      res_r <= cur;
    end
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

@@ src/ata_pio_command_sequencer_core.sv @@
// ATA PIO LBA-28 host sequencer. Requests, status replies and data words are
// taken at one per cycle while in_full is low; each is classified against the
// transfer phase at once and, where it causes bus accesses, queued as a job for
// up to QUEUE_DEPTH jobs. The result side expands one job into accesses at one
// result per cycle unless the output stalls; a request gives 2*SETTLE_READS+7
// results, an error recovery 2*SETTLE_READS+3, a read data word two, any other
// status reply during polling one or none, and a write data word one or two;
// that expander and its output register set the sustained rate. Configuration is
// written with cfg_ready always high.
module ata_pio_command_sequencer_core #(
  parameter int unsigned SETTLE_READS = 5,
  parameter int unsigned QUEUE_DEPTH  = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [1:0]  in_op,
  input  logic [27:0] in_block_addr,
  input  logic [7:0]  in_sector_count,
  input  logic [15:0] in_data_in,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [2:0]  out_kind,
  output logic [15:0] out_bus_addr,
  output logic [15:0] out_value,
  output logic        out_failed,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  apsq_pkg::cfg_t    cfg_r, cfg_nxt;
  apsq_pkg::job_t    fr_job, q_head;
  apsq_pkg::result_t res;
  logic              fr_push, q_full, q_valid, q_pop, res_valid, accept;

  assign cfg_ready = 1'b1;
  assign accept    = in_push && !q_full;
  assign in_full   = q_full;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (apsq_pkg::cfg_idx_t'(cfg_index))
        apsq_pkg::CFG_CMD_BASE:    cfg_nxt.cmd_base    = cfg_data;
        apsq_pkg::CFG_CTRL_BASE:   cfg_nxt.ctrl_base   = cfg_data;
        apsq_pkg::CFG_DRIVE_SLAVE: cfg_nxt.drive_slave = cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cmd_base    <= 16'h01f0;
      cfg_r.ctrl_base   <= 16'h03f4;
      cfg_r.drive_slave <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  apsq_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .op           (in_op),
    .block_addr   (in_block_addr),
    .sector_count (in_sector_count),
    .data_in      (in_data_in),
    .job_push     (fr_push),
    .job          (fr_job)
  );

  apsq_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (fr_push),
    .push_job (fr_job),
    .pop      (q_pop),
    .full     (q_full),
    .valid    (q_valid),
    .head     (q_head)
  );

  apsq_back #(
    .SETTLE_READS (SETTLE_READS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .job_valid (q_valid),
    .job       (q_head),
    .job_pop   (q_pop),
    .res_pop   (out_pop),
    .res_valid (res_valid),
    .res       (res)
  );

  assign out_empty    = !res_valid;
  assign out_kind     = res.kind;
  assign out_bus_addr = res.bus_addr;
  assign out_value    = res.value;
  assign out_failed   = res.failed;
  assign out_last     = res.last;

endmodule

@@ src/apsq_checker.sv @@
module apsq_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_empty,
  input logic        out_pop,
  input logic [2:0]  out_kind,
  input logic [15:0] out_bus_addr,
  input logic [15:0] out_value,
  input logic        out_failed,
  input logic        out_last
);

  // a waiting result holds until its transfer
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_kind)
      && $stable(out_bus_addr) && $stable(out_value) && $stable(out_last)))
    else $error("result changed while waiting");

  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_kind == apsq_pkg::KIND_DONE) |-> out_last)
    else $error("finished result not marked last");

  a_failed_done: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_failed) |-> (out_kind == apsq_pkg::KIND_DONE))
    else $error("failed flag on a bus access");

  a_host_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && (out_kind == apsq_pkg::KIND_HOST || out_kind == apsq_pkg::KIND_DONE))
      |-> (out_bus_addr == 16'd0))
    else $error("address on host word or finished result");

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result present after reset");

endmodule

bind ata_pio_command_sequencer_core apsq_checker u_apsq_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_empty    (out_empty),
  .out_pop      (out_pop),
  .out_kind     (out_kind),
  .out_bus_addr (out_bus_addr),
  .out_value    (out_value),
  .out_failed   (out_failed),
  .out_last     (out_last)
);

@@ bench/tb_ata_pio_command_sequencer_core.sv @@
`timescale 1ns / 1ps

module tb_ata_pio_command_sequencer_core;

  localparam int unsigned SETTLE_READS = 5;
  localparam int unsigned LIMIT        = 1000000;

  class ata_seq_scoreboard;
    logic [15:0]       cmd_base;
    logic [15:0]       ctrl_base;
    logic              drive_slave;
    apsq_pkg::phase_t  phase;
    logic              is_write;
    logic [15:0]       words_left;
    apsq_pkg::result_t access_q[$];
    int                errors;

    function new();
      cmd_base    = 16'h01f0;
      ctrl_base   = 16'h03f4;
      drive_slave = 1'b0;
      phase       = apsq_pkg::PH_IDLE;
      is_write    = 1'b0;
      words_left  = '0;
      errors      = 0;
    endfunction

    function void set_reg(apsq_pkg::cfg_idx_t idx, logic [15:0] d);
      unique case (idx)
        apsq_pkg::CFG_CMD_BASE:    cmd_base = d;
        apsq_pkg::CFG_CTRL_BASE:   ctrl_base = d;
        apsq_pkg::CFG_DRIVE_SLAVE: drive_slave = d[0];
        default: ;
      endcase
    endfunction

    function void add(apsq_pkg::kind_t k, logic [15:0] addr, logic [15:0] val, logic fl);
      apsq_pkg::result_t r;
      r.kind     = k;
      r.bus_addr = addr;
      r.value    = val;
      r.failed   = fl;
      r.last     = 1'b0;
      access_q.push_back(r);
    endfunction

    function void add_settle_reads();
      for (int i = 0; i < SETTLE_READS; i++) begin
        add(apsq_pkg::KIND_SETTLE, ctrl_base + apsq_pkg::OFS_ALTSTAT, '0, 1'b0);
      end
    endfunction

    function void add_done(logic fl);
      add(apsq_pkg::KIND_DONE, '0, '0, fl);
      phase = apsq_pkg::PH_IDLE;
    endfunction

    function void note_input(apsq_pkg::op_t op, logic [27:0] lba, logic [7:0] cnt,
                             logic [15:0] din);
      int unsigned       n_prev;
      logic [7:0]        st;
      logic [7:0]        sel;
      apsq_pkg::result_t r;
      n_prev = access_q.size();
      st = din[7:0];
      unique case (op)
        apsq_pkg::OP_READ_REQ, apsq_pkg::OP_WRITE_REQ: begin
          if (phase == apsq_pkg::PH_IDLE) begin
            sel = (drive_slave ? apsq_pkg::SEL_SLAVE : apsq_pkg::SEL_MASTER)
                  | {4'h0, lba[27:24]};
            is_write = (op == apsq_pkg::OP_WRITE_REQ);
            words_left = {cnt, 8'h00};
            add(apsq_pkg::KIND_BWRITE, cmd_base + apsq_pkg::OFS_DRIVE, {8'h00, sel}, 1'b0);
            add_settle_reads();
            add(apsq_pkg::KIND_BWRITE, cmd_base + apsq_pkg::OFS_COUNT, {8'h00, cnt}, 1'b0);
            add(apsq_pkg::KIND_BWRITE, cmd_base + apsq_pkg::OFS_LBA_LO,
                {8'h00, lba[7:0]}, 1'b0);
            add(apsq_pkg::KIND_BWRITE, cmd_base + apsq_pkg::OFS_LBA_MID,
                {8'h00, lba[15:8]}, 1'b0);
            add(apsq_pkg::KIND_BWRITE, cmd_base + apsq_pkg::OFS_LBA_HI,
                {8'h00, lba[23:16]}, 1'b0);
            add(apsq_pkg::KIND_BWRITE, cmd_base + apsq_pkg::OFS_CMD,
                {8'h00, (is_write ? apsq_pkg::CMD_WRITE : apsq_pkg::CMD_READ)}, 1'b0);
            add_settle_reads();
            add(apsq_pkg::KIND_BREAD, cmd_base + apsq_pkg::OFS_CMD, '0, 1'b0);
            phase = apsq_pkg::PH_POLL;
          end
        end
        apsq_pkg::OP_REPLY: begin
          if (phase == apsq_pkg::PH_POLL) begin
            if (st[apsq_pkg::ST_ERR]) begin
              add(apsq_pkg::KIND_BWRITE, ctrl_base + apsq_pkg::OFS_ALTSTAT,
                  {8'h00, apsq_pkg::SRST_BIT}, 1'b0);
              add_settle_reads();
              add(apsq_pkg::KIND_BWRITE, ctrl_base + apsq_pkg::OFS_ALTSTAT, '0, 1'b0);
              add_settle_reads();
              add_done(1'b1);
              words_left = '0;
            end else if (!st[apsq_pkg::ST_BSY] && st[apsq_pkg::ST_DRQ]) begin
              if (words_left == 0) begin
                add_done(1'b0);
              end else if (is_write) begin
                phase = apsq_pkg::PH_WDATA;
              end else begin
                add(apsq_pkg::KIND_WREAD, cmd_base + apsq_pkg::OFS_DATA, '0, 1'b0);
                phase = apsq_pkg::PH_RDATA;
              end
            end else begin
              add(apsq_pkg::KIND_BREAD, cmd_base + apsq_pkg::OFS_CMD, '0, 1'b0);
            end
          end else if (phase == apsq_pkg::PH_RDATA) begin
            add(apsq_pkg::KIND_HOST, '0, din, 1'b0);
            words_left = words_left - 16'd1;
            if (words_left == 0) begin
              add_done(1'b0);
            end else begin
              add(apsq_pkg::KIND_WREAD, cmd_base + apsq_pkg::OFS_DATA, '0, 1'b0);
            end
          end
        end
        apsq_pkg::OP_HOST_WORD: begin
          if (phase == apsq_pkg::PH_WDATA) begin
            add(apsq_pkg::KIND_WWRITE, cmd_base + apsq_pkg::OFS_DATA, din, 1'b0);
            words_left = words_left - 16'd1;
            if (words_left == 0) begin
              add_done(1'b0);
            end
          end
        end
        default: ;
      endcase
      if (access_q.size() > n_prev) begin
        r = access_q.pop_back();
        r.last = 1'b1;
        access_q.push_back(r);
      end
    endfunction

    function void check_result(logic [2:0] kind, logic [15:0] addr, logic [15:0] val,
                               logic fl, logic lst);
      apsq_pkg::result_t e;
      if (access_q.size() == 0) begin
        $error("unexpected result: kind %0d bus_addr %h value %h", kind, addr, val);
        errors++;
        return;
      end
      e = access_q.pop_front();
      if (kind !== e.kind) begin
        $error("kind: expected %0d, actual %0d", e.kind, kind);
        errors++;
      end
      if (addr !== e.bus_addr) begin
        $error("bus_addr: expected %h, actual %h", e.bus_addr, addr);
        errors++;
      end
      if (val !== e.value) begin
        $error("value: expected %h, actual %h", e.value, val);
        errors++;
      end
      if (fl !== e.failed) begin
        $error("failed: expected %0d, actual %0d", e.failed, fl);
        errors++;
      end
      if (lst !== e.last) begin
        $error("last: expected %0d, actual %0d", e.last, lst);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic [1:0]  in_op = '0;
  logic [27:0] in_block_addr = '0;
  logic [7:0]  in_sector_count = '0;
  logic [15:0] in_data_in = '0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic [2:0]  out_kind;
  logic [15:0] out_bus_addr;
  logic [15:0] out_value;
  logic        out_failed;
  logic        out_last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  ata_seq_scoreboard sb = new();

  int          in_run = 0;
  bit          in_calm = 1'b0;
  int          out_run = 0;
  bit          out_calm = 1'b0;
  int unsigned cycles = 0;

  ata_pio_command_sequencer_core #(
    .SETTLE_READS(SETTLE_READS)
  ) i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_op          (in_op),
    .in_block_addr  (in_block_addr),
    .in_sector_count(in_sector_count),
    .in_data_in     (in_data_in),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_kind       (out_kind),
    .out_bus_addr   (out_bus_addr),
    .out_value      (out_value),
    .out_failed     (out_failed),
    .out_last       (out_last),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // calm stretches give back-to-back transfers, the rest random gaps
  function automatic int pick_wait(inout int run, inout bit calm);
    if (run == 0) begin
      run = int'($urandom_range(4, 40));
      calm = ($urandom_range(0, 3) == 0);
    end
    run--;
    return calm ? 0 : int'($urandom_range(0, 19));
  endfunction

  function automatic logic [15:0] busy_status();
    logic [15:0] d;
    d = 16'($urandom);
    d[apsq_pkg::ST_ERR] = 1'b0;
    if (!d[apsq_pkg::ST_BSY]) begin
      d[apsq_pkg::ST_DRQ] = 1'b0;
    end
    return d;
  endfunction

  function automatic logic [15:0] ok_status();
    logic [15:0] d;
    d = 16'($urandom);
    d[apsq_pkg::ST_ERR] = 1'b0;
    d[apsq_pkg::ST_BSY] = 1'b0;
    d[apsq_pkg::ST_DRQ] = 1'b1;
    return d;
  endfunction

  function automatic logic [15:0] err_status();
    logic [15:0] d;
    d = 16'($urandom);
    d[apsq_pkg::ST_ERR] = 1'b1;
    return d;
  endfunction

  task automatic push_item(apsq_pkg::op_t op, logic [27:0] lba, logic [7:0] cnt,
                           logic [15:0] din);
    int   gap;
    logic full_s;
    gap = pick_wait(in_run, in_calm);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push         <= 1'b1;
    in_op           <= op;
    in_block_addr   <= lba;
    in_sector_count <= cnt;
    in_data_in      <= din;
    do begin
      @(negedge clk);
      full_s = in_full;
      @(posedge clk);
    end while (full_s);
    sb.note_input(op, lba, cnt, din);
  endtask

  task automatic write_config(logic [15:0] cb, logic [15:0] ctb, logic slave);
    apsq_pkg::cfg_idx_t idx;
    logic [15:0]        d;
    logic               rdy;
    in_push <= 1'b0;
    while (sb.access_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    for (int i = 0; i < 3; i++) begin
      idx = apsq_pkg::cfg_idx_t'(i);
      d = (idx == apsq_pkg::CFG_CMD_BASE) ? cb :
          (idx == apsq_pkg::CFG_CTRL_BASE) ? ctb : {15'd0, slave};
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= d;
      do begin
        @(negedge clk);
        rdy = cfg_ready;
        @(posedge clk);
      end while (!rdy);
      sb.set_reg(idx, d);
    end
    cfg_valid <= 1'b0;
  endtask

  // data words, with the odd stray item that must be ignored
  task automatic run_data(int unsigned n);
    repeat (n) begin
      if ($urandom_range(0, 15) == 0) begin
        if ($urandom_range(0, 1) == 0) begin
          push_item(apsq_pkg::op_t'($urandom_range(0, 1)), 28'($urandom), 8'($urandom),
                    16'($urandom));
        end else begin
          push_item(sb.phase == apsq_pkg::PH_RDATA ? apsq_pkg::OP_HOST_WORD
                                                   : apsq_pkg::OP_REPLY,
                    28'($urandom), 8'($urandom), 16'($urandom));
        end
      end else begin
        push_item(sb.phase == apsq_pkg::PH_RDATA ? apsq_pkg::OP_REPLY
                                                 : apsq_pkg::OP_HOST_WORD,
                  28'($urandom), 8'($urandom), 16'($urandom));
      end
    end
  endtask

  task automatic run_transfer(apsq_pkg::op_t op, logic [7:0] cnt, bit fail);
    push_item(op, 28'($urandom), cnt, 16'($urandom));
    repeat ($urandom_range(0, 3)) begin
      if ($urandom_range(0, 5) == 0) begin
        push_item($urandom_range(0, 1) ? apsq_pkg::OP_HOST_WORD
                                       : apsq_pkg::op_t'($urandom_range(0, 1)),
                  28'($urandom), 8'($urandom), 16'($urandom));
      end
      push_item(apsq_pkg::OP_REPLY, 28'($urandom), 8'($urandom), busy_status());
    end
    push_item(apsq_pkg::OP_REPLY, 28'($urandom), 8'($urandom),
              fail ? err_status() : ok_status());
  endtask

  // random items in any order, then the open transfer is wound up
  task automatic run_noise();
    apsq_pkg::op_t op;
    logic [15:0]   d;
    repeat ($urandom_range(1, 6)) begin
      op = apsq_pkg::op_t'($urandom_range(0, 3));
      d = 16'($urandom);
      if (op == apsq_pkg::OP_REPLY && sb.phase == apsq_pkg::PH_POLL
          && sb.words_left != 16'd0 && !d[apsq_pkg::ST_ERR]) begin
        d[apsq_pkg::ST_DRQ] = 1'b0;
      end
      push_item(op, 28'($urandom), 8'($urandom), d);
    end
    while (sb.phase == apsq_pkg::PH_POLL) begin
      push_item(apsq_pkg::OP_REPLY, 28'($urandom), 8'($urandom), err_status());
    end
  endtask

  // a transfer that enters its data phase and is left open
  task automatic run_open_transfer(apsq_pkg::op_t op);
    push_item(op, 28'($urandom), 8'($urandom_range(1, 255)), 16'($urandom));
    push_item(apsq_pkg::OP_REPLY, 28'($urandom), 8'($urandom), ok_status());
    run_data($urandom_range(8, 16));
  endtask

  initial begin : pop_side
    int          stall;
    logic        empty_s;
    logic [2:0]  kind_s;
    logic [15:0] addr_s;
    logic [15:0] value_s;
    logic        failed_s;
    logic        last_s;
    wait (rst_n);
    @(posedge clk);
    forever begin
      stall = pick_wait(out_run, out_calm);
      if (stall > 0) begin
        out_pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_pop <= 1'b1;
      do begin
        @(negedge clk);
        empty_s  = out_empty;
        kind_s   = out_kind;
        addr_s   = out_bus_addr;
        value_s  = out_value;
        failed_s = out_failed;
        last_s   = out_last;
        @(posedge clk);
      end while (empty_s);
      sb.check_result(kind_s, addr_s, value_s, failed_s, last_s);
    end
  end

  initial begin : push_side
    int r;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_config(16'h01f0, 16'h03f4, 1'b0);
    push_item(apsq_pkg::OP_READ_REQ, 28'h0000000, 8'h00, 16'h0000);
    push_item(apsq_pkg::OP_REPLY, '0, '0, 16'h0080);
    push_item(apsq_pkg::OP_REPLY, '0, '0, 16'h0088);
    push_item(apsq_pkg::OP_HOST_WORD, '0, '0, 16'hffff);
    push_item(apsq_pkg::OP_WRITE_REQ, 28'hfffffff, 8'hff, 16'h0000);
    push_item(apsq_pkg::OP_REPLY, '0, '0, 16'h0008);
    push_item(apsq_pkg::OP_REPLY, '0, '0, 16'h0008);
    push_item(apsq_pkg::OP_HOST_WORD, '0, '0, 16'h1234);
    push_item(apsq_pkg::OP_WRITE_REQ, 28'hfffffff, 8'hff, 16'hffff);
    push_item(apsq_pkg::OP_REPLY, '0, '0, 16'h00ff);
    push_item(apsq_pkg::OP_WRITE_REQ, 28'h0abcdef, 8'h00, 16'h0000);
    push_item(apsq_pkg::OP_REPLY, '0, '0, 16'hff08);
    push_item(apsq_pkg::OP_READ_REQ, 28'h5a5a5a5, 8'h80, 16'h0000);
    push_item(apsq_pkg::OP_REPLY, '0, '0, 16'h0001);

    // address wrap at the top of the I/O space, slave drive
    write_config(16'hffff, 16'hfffe, 1'b1);
    push_item(apsq_pkg::OP_READ_REQ, 28'hfffffff, 8'h00, 16'h0000);
    push_item(apsq_pkg::OP_REPLY, '0, '0, 16'h0000);
    push_item(apsq_pkg::OP_REPLY, '0, '0, 16'h0008);
    push_item(apsq_pkg::OP_WRITE_REQ, 28'h8000000, 8'h01, 16'h0000);
    push_item(apsq_pkg::OP_REPLY, '0, '0, 16'hff01);
    push_item(apsq_pkg::OP_READ_REQ, 28'h0000001, 8'h01, 16'h0000);
    push_item(apsq_pkg::OP_REPLY, '0, '0, 16'h0009);

    for (int s = 0; s < 24; s++) begin
      if (s % 6 == 0) begin
        case (s / 6)
          0: write_config(16'($urandom), 16'($urandom), 1'($urandom_range(0, 1)));
          1: write_config(16'h0000, 16'h0000, 1'b0);
          2: write_config(16'hffff, 16'hffff, 1'b1);
          default: write_config(16'h01f0, 16'h03f4, 1'b0);
        endcase
      end
      r = int'($urandom_range(0, 99));
      if (r < 25) begin
        run_noise();
      end else if (r < 60) begin
        run_transfer(apsq_pkg::op_t'($urandom_range(0, 1)), 8'h00, 1'b0);
      end else begin
        run_transfer(apsq_pkg::op_t'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                     1'b1);
      end
    end
    run_open_transfer(apsq_pkg::op_t'($urandom_range(0, 1)));
    in_push <= 1'b0;

    while (sb.access_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.errors == 0 && sb.access_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
